// ----- rtl/htfd_pkg.sv -----
// shared types, constants and the crc-8 byte update for the sensor frame decoder
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package htfd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned POS_W  = 3;
   localparam int unsigned TEMP_W = 15;
   localparam int unsigned HUM_W  = 14;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   // frame byte positions
   localparam logic [POS_W-1:0] POS_TEMP_HI  = 3'd0;
   localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd1;
   localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
   localparam logic [POS_W-1:0] POS_HUM_HI   = 3'd3;
   localparam logic [POS_W-1:0] POS_HUM_LO   = 3'd4;
   localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;

   // scaling constants (hundredths)
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;

   // one completed frame, handed from the collector to the scaler
   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] temp_word;
      logic [WORD_W-1:0] hum_word;
      logic              temp_ok;
      logic              hum_ok;
   } frame_type;

   // crc-8, msb first, one byte
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/htfd_if.sv -----
// valid/ready channel interfaces for reply bytes and decoded frames
// depends on htfd_pkg for field widths
`default_nettype none

interface htfd_req_if;
   import htfd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_rsp_if;
   import htfd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centi;
   logic [HUM_W-1:0]         humidity_centi;
   logic [WORD_W-1:0]        temperature_raw;
   logic [WORD_W-1:0]        humidity_raw;
   logic                     temperature_check_ok;
   logic                     humidity_check_ok;

   modport source (output valid, output temperature_centi, output humidity_centi,
                   output temperature_raw, output humidity_raw,
                   output temperature_check_ok, output humidity_check_ok, input ready);
   modport sink   (input valid, input temperature_centi, input humidity_centi,
                   input temperature_raw, input humidity_raw,
                   input temperature_check_ok, input humidity_check_ok, output ready);
endinterface

`default_nettype wire

// ----- rtl/htfd_collect.sv -----
// byte position tracking, word assembly and crc checking of one reply frame
// depends on htfd_pkg
`default_nettype none

module htfd_collect
   import htfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire logic              frame_start,
   output frame_type              frame
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [WORD_W-1:0] temp_ff, temp_in;
   logic [WORD_W-1:0] hum_ff, hum_in;
   logic              tmatch_ff, tmatch_in;

   logic [POS_W-1:0]  pos;
   logic [BYTE_W-1:0] crc_base;
   logic [BYTE_W-1:0] crc_next;

   always_comb begin
      pos      = pos_ff;
      crc_base = crc_ff;
      if (frame_start) begin
         pos      = POS_TEMP_HI;
         crc_base = CRC_INIT;
      end
      if (pos > POS_HUM_CRC) begin
         pos = POS_TEMP_HI;
      end
   end

   assign crc_next = crc8_byte(crc_base, rx_byte);

   always_comb begin
      pos_in    = pos + 1'b1;
      crc_in    = crc_next;
      temp_in   = temp_ff;
      hum_in    = hum_ff;
      tmatch_in = tmatch_ff;
      frame     = '{done: 1'b0, temp_word: temp_ff, hum_word: hum_ff,
                    temp_ok: tmatch_ff, hum_ok: (crc_base == rx_byte)};
      unique case (pos)
         POS_TEMP_HI: begin
            temp_in = {rx_byte, {BYTE_W{1'b0}}};
         end
         POS_TEMP_LO: begin
            temp_in = {temp_ff[WORD_W-1:BYTE_W], rx_byte};
         end
         POS_TEMP_CRC: begin
            tmatch_in = (crc_base == rx_byte);
            crc_in    = CRC_INIT;
         end
         POS_HUM_HI: begin
            hum_in = {rx_byte, {BYTE_W{1'b0}}};
         end
         POS_HUM_LO: begin
            hum_in = {hum_ff[WORD_W-1:BYTE_W], rx_byte};
         end
         default: begin
            crc_in     = CRC_INIT;
            pos_in     = POS_TEMP_HI;
            frame.done = accept;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_TEMP_HI;
         crc_ff    <= CRC_INIT;
         temp_ff   <= '0;
         hum_ff    <= '0;
         tmatch_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         tmatch_ff <= tmatch_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/htfd_scale.sv -----
// fixed-point scaling of the raw words to hundredths of a degree and percent
// depends on htfd_pkg; divide by 65535 via shift plus one-step correction
`default_nettype none

module htfd_scale
   import htfd_pkg::*;
(
   input  wire logic [WORD_W-1:0]        temp_word,
   input  wire logic [WORD_W-1:0]        hum_word,
   output logic signed [TEMP_W-1:0]      temperature_centi,
   output logic [HUM_W-1:0]              humidity_centi
);

   logic [30:0] t_prod;
   logic [14:0] t_q0;
   logic [16:0] t_rem;
   logic [14:0] t_q;

   logic [29:0] h_prod;
   logic [13:0] h_q0;
   logic [16:0] h_rem;

   function automatic logic [30:0] t_span_mul(input logic [WORD_W-1:0] w);
      return {15'd0, w} * {16'd0, TEMP_SPAN};
   endfunction

   // x / 65535: q0 = x >> 16 is low by at most one, remainder is lo + q0
   always_comb begin
      t_prod = 31'(t_span_mul(temp_word));
      t_q0   = t_prod[30:16];
      t_rem  = {1'b0, t_prod[15:0]} + {2'b00, t_q0};
      t_q    = t_q0 + 15'(t_rem >= FULL_SCALE);
      temperature_centi = signed'(t_q - TEMP_OFFSET);

      h_prod = 30'({14'd0, hum_word} * {16'd0, HUM_SPAN});
      h_q0   = h_prod[29:16];
      h_rem  = {1'b0, h_prod[15:0]} + {3'b000, h_q0};
      humidity_centi = h_q0 + 14'(h_rem >= FULL_SCALE);
   end

endmodule

`default_nettype wire

// ----- rtl/humidity_temp_frame_decoder.sv -----
// top level of the sensor reply frame decoder: collector, scaler, result register
// depends on htfd_pkg, htfd_if, htfd_collect and htfd_scale
//
//   channel | dir | fields                                        | per word
//   req_ch  | in  | rx_byte, frame_start                          | one reply byte
//   rsp_ch  | out | temperature_centi, humidity_centi, raw words, | one decoded frame
//           |     | temperature_check_ok, humidity_check_ok       |
//
// one byte per cycle when the byte input is not stalled: the crc update and word
// assembly run between the frame state registers and the result register;
// the frame result appears in the cycle after its sixth byte is taken
// reset (synchronous) clears the byte position, crc and result valid
// a full result register that is not taken stalls the byte input; the
// result register frees in the same cycle it is read, so there is no bubble
`default_nettype none

module humidity_temp_frame_decoder
   import htfd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   htfd_req_if.sink   req_ch,
   htfd_rsp_if.source rsp_ch
);

   logic      accept;
   frame_type frame;

   logic signed [TEMP_W-1:0] t_centi;
   logic [HUM_W-1:0]         h_centi;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] t_centi_ff;
   logic [HUM_W-1:0]         h_centi_ff;
   logic [WORD_W-1:0]        t_raw_ff;
   logic [WORD_W-1:0]        h_raw_ff;
   logic                     t_ok_ff;
   logic                     h_ok_ff;

   // take a byte whenever the result slot is empty or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   htfd_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_ch.rx_byte),
      .frame_start (req_ch.frame_start),
      .frame       (frame)
   );

   // scaling uses the stored words, both complete by the last byte
   htfd_scale u_scale (
      .temp_word         (frame.temp_word),
      .hum_word          (frame.hum_word),
      .temperature_centi (t_centi),
      .humidity_centi    (h_centi)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (frame.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only when a frame completes
   always_ff @(posedge clock) begin
      if (frame.done) begin
         t_centi_ff <= t_centi;
         h_centi_ff <= h_centi;
         t_raw_ff   <= frame.temp_word;
         h_raw_ff   <= frame.hum_word;
         t_ok_ff    <= frame.temp_ok;
         h_ok_ff    <= frame.hum_ok;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.temperature_centi    = t_centi_ff;
   assign rsp_ch.humidity_centi       = h_centi_ff;
   assign rsp_ch.temperature_raw      = t_raw_ff;
   assign rsp_ch.humidity_raw         = h_raw_ff;
   assign rsp_ch.temperature_check_ok = t_ok_ff;
   assign rsp_ch.humidity_check_ok    = h_ok_ff;

endmodule

`default_nettype wire

// ----- tb/sv/htfd_frame_checker.sv -----
// frame checker for the sensor reply decoder: predicts each decoded frame from the
// accepted reply bytes and compares it with the result channel
// depends on htfd_pkg and htfd_if
module htfd_frame_checker
   import htfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   htfd_req_if         req_ch,
   htfd_rsp_if         rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned frames_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEMP_SPAN_C   = 17500;
   localparam int TEMP_OFFSET_C = 4500;
   localparam int HUM_SPAN_C    = 10000;
   localparam int FULL_SCALE_C  = 65535;

   typedef struct {
      logic signed [TEMP_W-1:0] temp_centi;
      logic [HUM_W-1:0]         hum_centi;
      logic [WORD_W-1:0]        temp_raw;
      logic [WORD_W-1:0]        hum_raw;
      logic                     temp_ok;
      logic                     hum_ok;
   } frame_result_type;

   frame_result_type expected_frames[$];

   logic [POS_W-1:0]  next_pos;
   logic [BYTE_W-1:0] crc_reg;
   logic [WORD_W-1:0] temp_word;
   logic [WORD_W-1:0] hum_word;
   logic              temp_match;

   // bitwise crc-8, poly 0x31, msb first
   function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      logic              fb;
      r = crc_in;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = r[BYTE_W-1] ^ data[i];
         r  = {r[BYTE_W-2:0], 1'b0};
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   task automatic decode_reply_byte(input logic [BYTE_W-1:0] rx_val, input logic start);
      logic [POS_W-1:0] p;
      frame_result_type res;
      int               t_scaled;
      int               h_scaled;
      p = next_pos;
      if (start) begin
         p       = POS_TEMP_HI;
         crc_reg = CRC_INIT;
      end
      if (p > POS_HUM_CRC) p = POS_TEMP_HI;
      case (p)
         POS_TEMP_HI: begin
            temp_word = {rx_val, 8'h00};
            crc_reg   = crc8_next(crc_reg, rx_val);
         end
         POS_TEMP_LO: begin
            temp_word[7:0] = rx_val;
            crc_reg        = crc8_next(crc_reg, rx_val);
         end
         POS_TEMP_CRC: begin
            temp_match = (crc_reg == rx_val);
            crc_reg    = CRC_INIT;
         end
         POS_HUM_HI: begin
            hum_word = {rx_val, 8'h00};
            crc_reg  = crc8_next(crc_reg, rx_val);
         end
         POS_HUM_LO: begin
            hum_word[7:0] = rx_val;
            crc_reg       = crc8_next(crc_reg, rx_val);
         end
         default: begin
            res.hum_ok     = (crc_reg == rx_val);
            crc_reg        = CRC_INIT;
            t_scaled       = (TEMP_SPAN_C * int'(temp_word)) / FULL_SCALE_C;
            h_scaled       = (HUM_SPAN_C * int'(hum_word)) / FULL_SCALE_C;
            res.temp_centi = TEMP_W'(t_scaled - TEMP_OFFSET_C);
            res.hum_centi  = HUM_W'(h_scaled);
            res.temp_raw   = temp_word;
            res.hum_raw    = hum_word;
            res.temp_ok    = temp_match;
            expected_frames.push_back(res);
         end
      endcase
      next_pos = (p == POS_HUM_CRC) ? POS_TEMP_HI : p + 1'b1;
   endtask

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic compare_frame();
      frame_result_type want;
      if (expected_frames.size() == 0) begin
         $error("frame result with no frame pending: temperature_raw %0d humidity_raw %0d",
                rsp_ch.temperature_raw, rsp_ch.humidity_raw);
         mismatch_count++;
      end else begin
         want = expected_frames.pop_front();
         check_field("temperature_centi", int'(want.temp_centi),
                     int'(rsp_ch.temperature_centi));
         check_field("humidity_centi", int'(want.hum_centi), int'(rsp_ch.humidity_centi));
         check_field("temperature_raw", int'(want.temp_raw), int'(rsp_ch.temperature_raw));
         check_field("humidity_raw", int'(want.hum_raw), int'(rsp_ch.humidity_raw));
         check_field("temperature_check_ok", int'(want.temp_ok),
                     int'(rsp_ch.temperature_check_ok));
         check_field("humidity_check_ok", int'(want.hum_ok), int'(rsp_ch.humidity_check_ok));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         next_pos       = POS_TEMP_HI;
         crc_reg        = CRC_INIT;
         temp_word      = '0;
         hum_word       = '0;
         temp_match     = 1'b0;
         mismatch_count = 0;
         expected_frames.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) decode_reply_byte(req_ch.rx_byte, req_ch.frame_start);
         if (rsp_ch.valid && rsp_ch.ready) compare_frame();
      end
      frames_pending <= expected_frames.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top for the sensor reply frame decoder: clock, reset, byte stimulus,
// result back-pressure, watchdog and verdict; checking is in htfd_frame_checker
// depends on htfd_pkg, htfd_if, humidity_temp_frame_decoder and htfd_frame_checker
module tb;
   import htfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_HALF      = 5;
   localparam int          RESET_CYCLES  = 4;
   localparam int          PHASE_BYTES   = 667;
   localparam int          DRAIN_CYCLES  = 10;
   localparam int unsigned STALL_LIMIT   = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   htfd_req_if req_ch ();
   htfd_rsp_if rsp_ch ();

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned bytes_sent;
   int unsigned stall_cycles;
   int unsigned mismatch_count;
   int unsigned frames_pending;

   always #CLK_HALF clock = ~clock;

   humidity_temp_frame_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   htfd_frame_checker frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .frames_pending (frames_pending)
   );

   // result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: cycles with no word taken on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // one reply byte; random idle cycles before it, then hold until taken
   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.rx_byte     <= value;
      req_ch.frame_start <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // first len bytes of a reply frame; a bad check byte is the good one with some bits flipped
   task automatic send_frame(input logic [WORD_W-1:0] t_word, input logic [WORD_W-1:0] h_word,
                             input logic t_good, input logic h_good, input logic start,
                             input int len);
      logic [BYTE_W-1:0] frame_bytes[6];
      logic [BYTE_W-1:0] crc_t;
      logic [BYTE_W-1:0] crc_h;
      crc_t = crc8_byte(crc8_byte(CRC_INIT, t_word[15:8]), t_word[7:0]);
      crc_h = crc8_byte(crc8_byte(CRC_INIT, h_word[15:8]), h_word[7:0]);
      if (!t_good) crc_t = crc_t ^ BYTE_W'($urandom_range(1, 255));
      if (!h_good) crc_h = crc_h ^ BYTE_W'($urandom_range(1, 255));
      frame_bytes = '{t_word[15:8], t_word[7:0], crc_t, h_word[15:8], h_word[7:0], crc_h};
      for (int i = 0; i < len; i++) send_byte(frame_bytes[i], (i == 0) ? start : 1'b0);
   endtask

   // raw words lean toward the ends of the scale now and then
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   task automatic random_traffic(input int n_bytes);
      int unsigned target;
      int unsigned kind;
      int unsigned n_noise;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            // well-formed frame, mostly with good check bytes
            send_frame(pick_word(), pick_word(), $urandom_range(99) < 85,
                       $urandom_range(99) < 85, $urandom_range(99) < 70, 6);
         end else if (kind < 90) begin
            // frame cut short, the next frame start has to resync
            send_frame(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1, $urandom_range(1, 5));
         end else begin
            // loose noise bytes, sometimes flagged as a frame start
            n_noise = $urandom_range(1, 8);
            repeat (n_noise) send_byte(BYTE_W'($urandom), $urandom_range(99) < 15);
         end
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.rx_byte     = '0;
      req_ch.frame_start = 1'b0;
      send_idle_pct      = 9;
      recv_idle_pct      = 65;
      bytes_sent         = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      // all-zero words straight after reset, no frame start flag needed
      send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 6);
      // full-scale words: top of both ranges
      send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
      // both check bytes wrong
      send_frame(16'h1234, 16'hABCD, 1'b0, 1'b0, 1'b1, 6);
      // partial frame dropped by a new frame start, temperature check wrong only
      send_frame(16'h8000, 16'h0001, 1'b1, 1'b1, 1'b1, 2);
      send_frame(16'h0001, 16'h8000, 1'b0, 1'b1, 1'b1, 6);

      // sender lightly idle, receiver heavily stalled
      random_traffic(PHASE_BYTES);
      // roles swapped
      send_idle_pct <= 65;
      recv_idle_pct <= 9;
      random_traffic(PHASE_BYTES);
      // full rate on both sides
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      random_traffic(PHASE_BYTES);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
